/* rtl/sau_pkg.sv */
// Shared types and fixed-point constants for the sigmoid activation unit.
package sau_pkg;

    localparam int MAG_W = 16;   // |x| in Q.10, clamped to 32.0
    localparam int G_W   = 31;   // scaled argument in Q0.31
    localparam int ACC_W = 33;   // even / odd series partial sums
    localparam int EXP_W = 32;   // e^-a in Q0.31, up to 1.0

    localparam int SERIES_TERMS = 13;
    localparam int SQUARINGS    = 5;

    localparam logic [31:0]      LNE_Q32 = 32'd4294965987;   // ln(2.718281), Q0.32
    localparam logic [31:0]      ONE_Q31 = 32'h8000_0000;
    localparam logic [MAG_W-1:0] A_LIMIT = 16'd32768;

    // floor(2^32 / n), reciprocal estimates for the per-term divide by n
    localparam logic [31:0] RECIP_TAB [2:SERIES_TERMS] = '{
        32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
        32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099
    };

    typedef struct packed {
        logic valid;
        logic neg;
    } t_ctl;

endpackage

/* rtl/sau_skid.sv */
// Input skid buffer: registered ready toward the upstream stream.
module sau_skid import sau_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_data;
    logic             w_take;
    logic             w_load;

    assign o_ready = !r_skid_valid;
    assign w_take  = i_valid && !r_skid_valid;
    assign w_load  = i_ready || !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid  <= r_skid_valid || w_take;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (w_take) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

/* rtl/sau_exp.sv */
// Pipelined e^-a: argument scaling, Taylor series, repeated squaring.
module sau_exp import sau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  t_ctl             i_ctl,
    input  logic [MAG_W-1:0] i_mag,
    output t_ctl             o_ctl,
    output logic [EXP_W-1:0] o_w
);

    localparam int NT = SERIES_TERMS - 1;   // terms 2..13; term 1 is g itself

    // scaled argument stage
    t_ctl           r_g_ctl;
    logic [G_W-1:0] r_g;
    logic [47:0]    w_g_prod;

    assign w_g_prod = 48'(i_mag) * 48'(LNE_Q32) + 48'h8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_ctl <= '0;
        else if (i_ce) r_g_ctl <= i_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) r_g <= w_g_prod[46:16];
    end

    // per term: multiply by g, reciprocal estimate, correction
    t_ctl             w_src_ctl [NT];
    logic [G_W-1:0]   w_src_t   [NT];
    logic [G_W-1:0]   w_src_g   [NT];
    logic [ACC_W-1:0] w_src_pos [NT];
    logic [ACC_W-1:0] w_src_neg [NT];

    t_ctl             r_m_ctl [NT];
    logic [G_W-1:0]   r_m_p   [NT];
    logic [G_W-1:0]   r_m_g   [NT];
    logic [ACC_W-1:0] r_m_pos [NT];
    logic [ACC_W-1:0] r_m_neg [NT];

    t_ctl             r_r_ctl [NT];
    logic [G_W-1:0]   r_r_qe  [NT];
    logic [G_W-1:0]   r_r_p   [NT];
    logic [G_W-1:0]   r_r_g   [NT];
    logic [ACC_W-1:0] r_r_pos [NT];
    logic [ACC_W-1:0] r_r_neg [NT];

    t_ctl             r_c_ctl [NT];
    logic [G_W-1:0]   r_c_t   [NT];
    logic [G_W-1:0]   r_c_g   [NT];
    logic [ACC_W-1:0] r_c_pos [NT];
    logic [ACC_W-1:0] r_c_neg [NT];

    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int          N = j + 2;
        localparam logic [31:0] M = RECIP_TAB[N];

        logic [61:0] w_tg;
        logic [62:0] w_pm;
        logic [34:0] w_qn;
        logic [34:0] w_rem;

        if (j == 0) begin : g_first
            assign w_src_ctl[j] = r_g_ctl;
            assign w_src_t[j]   = r_g;
            assign w_src_g[j]   = r_g;
            assign w_src_pos[j] = ACC_W'(ONE_Q31);
            assign w_src_neg[j] = '0;
        end else begin : g_next
            assign w_src_ctl[j] = r_c_ctl[j-1];
            assign w_src_t[j]   = r_c_t[j-1];
            assign w_src_g[j]   = r_c_g[j-1];
            assign w_src_pos[j] = r_c_pos[j-1];
            assign w_src_neg[j] = r_c_neg[j-1];
        end

        assign w_tg  = 62'(w_src_t[j]) * 62'(w_src_g[j]);
        assign w_pm  = 63'(r_m_p[j]) * 63'(M);
        assign w_qn  = 35'(r_r_qe[j]) * 35'(N);
        assign w_rem = 35'(r_r_p[j]) - w_qn;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_ctl[j] <= '0;
                r_r_ctl[j] <= '0;
                r_c_ctl[j] <= '0;
            end else if (i_ce) begin
                r_m_ctl[j] <= w_src_ctl[j];
                r_r_ctl[j] <= r_m_ctl[j];
                r_c_ctl[j] <= r_r_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_m_p[j] <= w_tg[61:31];
                r_m_g[j] <= w_src_g[j];
                // the pending term is n-1: odd terms go to the negative sum
                if (N % 2 == 0) begin
                    r_m_pos[j] <= w_src_pos[j];
                    r_m_neg[j] <= w_src_neg[j] + ACC_W'(w_src_t[j]);
                end else begin
                    r_m_pos[j] <= w_src_pos[j] + ACC_W'(w_src_t[j]);
                    r_m_neg[j] <= w_src_neg[j];
                end

                r_r_qe[j]  <= w_pm[62:32];
                r_r_p[j]   <= r_m_p[j];
                r_r_g[j]   <= r_m_g[j];
                r_r_pos[j] <= r_m_pos[j];
                r_r_neg[j] <= r_m_neg[j];

                // estimate is exact or one low
                r_c_t[j]   <= r_r_qe[j] + G_W'(w_rem >= 35'(N));
                r_c_g[j]   <= r_r_g[j];
                r_c_pos[j] <= r_r_pos[j];
                r_c_neg[j] <= r_r_neg[j];
            end
        end
    end

    // last term into its sum, then difference and clamp
    t_ctl             r_f_ctl;
    logic [ACC_W-1:0] r_f_pos;
    logic [ACC_W-1:0] r_f_neg;
    t_ctl             r_d_ctl;
    logic [EXP_W-1:0] r_d_w;
    logic [ACC_W-1:0] w_diff;

    assign w_diff = r_f_pos - r_f_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl <= '0;
            r_d_ctl <= '0;
        end else if (i_ce) begin
            r_f_ctl <= r_c_ctl[NT-1];
            r_d_ctl <= r_f_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (SERIES_TERMS % 2 == 1) begin
                r_f_pos <= r_c_pos[NT-1];
                r_f_neg <= r_c_neg[NT-1] + ACC_W'(r_c_t[NT-1]);
            end else begin
                r_f_pos <= r_c_pos[NT-1] + ACC_W'(r_c_t[NT-1]);
                r_f_neg <= r_c_neg[NT-1];
            end

            if (r_f_pos <= r_f_neg) begin
                r_d_w <= '0;
            end else if (w_diff > ACC_W'(ONE_Q31)) begin
                r_d_w <= ONE_Q31;
            end else begin
                r_d_w <= w_diff[EXP_W-1:0];
            end
        end
    end

    // e^-a = (e^-a/32)^32
    t_ctl             r_sq_ctl [SQUARINGS];
    logic [EXP_W-1:0] r_sq_w   [SQUARINGS];

    for (genvar k = 0; k < SQUARINGS; k++) begin : g_sq
        t_ctl             w_ctl;
        logic [EXP_W-1:0] w_in;
        logic [63:0]      w_sq;

        if (k == 0) begin : g_first
            assign w_ctl = r_d_ctl;
            assign w_in  = r_d_w;
        end else begin : g_next
            assign w_ctl = r_sq_ctl[k-1];
            assign w_in  = r_sq_w[k-1];
        end

        assign w_sq = 64'(w_in) * 64'(w_in) + 64'h4000_0000;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_ctl[k] <= '0;
            else if (i_ce) r_sq_ctl[k] <= w_ctl;
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) r_sq_w[k] <= w_sq[62:31];
        end
    end

    assign o_ctl = r_sq_ctl[SQUARINGS-1];
    assign o_w   = r_sq_w[SQUARINGS-1];

endmodule

/* rtl/sau_recip.sv */
// Pipelined restoring divide: s = round(2^(31+OUT_WIDTH) / (1.0 + w)).
module sau_recip import sau_pkg::*; #(
    parameter int OUT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  t_ctl               i_ctl,
    input  logic [EXP_W-1:0]   i_w,
    output t_ctl               o_ctl,
    output logic [OUT_WIDTH:0] o_s
);

    localparam int NW = 32 + OUT_WIDTH;   // dividend width
    localparam int QW = OUT_WIDTH + 1;    // quotient bits, one per stage
    localparam int DW = 33;               // divisor, up to 2^32
    localparam int RW = 33;               // partial remainder, below divisor

    // divisor and dividend setup
    logic [DW-1:0] w_d;
    logic [NW-1:0] w_n;
    t_ctl          r_s_ctl;
    logic [DW-1:0] r_s_d;
    logic [RW-1:0] r_s_rem;
    logic [QW-1:0] r_s_nlow;

    assign w_d = DW'(i_w) + DW'(ONE_Q31);
    assign w_n = (NW'(1) << (31 + OUT_WIDTH)) + NW'(w_d[DW-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s_ctl <= '0;
        else if (i_ce) r_s_ctl <= i_ctl;
    end

    // upper dividend bits are always below the divisor
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s_d    <= w_d;
            r_s_rem  <= RW'(w_n[NW-1:QW]);
            r_s_nlow <= w_n[QW-1:0];
        end
    end

    t_ctl          r_q_ctl  [QW];
    logic [DW-1:0] r_q_d    [QW];
    logic [RW-1:0] r_q_rem  [QW];
    logic [QW-1:0] r_q_nlow [QW];
    logic [QW-1:0] r_q_q    [QW];

    for (genvar k = 0; k < QW; k++) begin : g_bit
        t_ctl          w_ctl;
        logic [DW-1:0] w_dv;
        logic [RW-1:0] w_rem;
        logic [QW-1:0] w_nlow;
        logic [QW-1:0] w_q;
        logic [RW:0]   w_sh;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_ctl  = r_s_ctl;
            assign w_dv   = r_s_d;
            assign w_rem  = r_s_rem;
            assign w_nlow = r_s_nlow;
            assign w_q    = '0;
        end else begin : g_next
            assign w_ctl  = r_q_ctl[k-1];
            assign w_dv   = r_q_d[k-1];
            assign w_rem  = r_q_rem[k-1];
            assign w_nlow = r_q_nlow[k-1];
            assign w_q    = r_q_q[k-1];
        end

        assign w_sh = {w_rem, w_nlow[QW-1-k]};
        assign w_ge = w_sh >= (RW+1)'(w_dv);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_q_ctl[k] <= '0;
            else if (i_ce) r_q_ctl[k] <= w_ctl;
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q_d[k]    <= w_dv;
                r_q_nlow[k] <= w_nlow;
                r_q_rem[k]  <= w_ge ? RW'(w_sh - (RW+1)'(w_dv)) : RW'(w_sh);
                r_q_q[k]    <= {w_q[QW-2:0], w_ge};
            end
        end
    end

    assign o_ctl = r_q_ctl[QW-1];
    assign o_s   = r_q_q[QW-1];

endmodule

/* rtl/sigmoid_activation_unit_core.sv */
// Top level: streaming logistic sigmoid, Q5.10 in, Q0.16 out.
// Register stages from input request to output: input buffer, magnitude, e^-|x|, divider, output.
// Throughput: one request per cycle; every stage has a valid bit and the whole
// pipeline holds together while the output request waits for m_axis_tready.
// Depth: 12 series terms of three stages, five squarings, one divider stage per quotient bit.
// Reset (i_rst_n, synchronous, active low) clears all valid bits; data is not reset.
module sigmoid_activation_unit_core import sau_pkg::*; #(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((IN_WIDTH + 7) / 8) * 8-1:0]  s_axis_tdata,   // x_value
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((OUT_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata    // y_value
);

    localparam int OUT_TW = ((OUT_WIDTH + 7) / 8) * 8;
    localparam int MW     = (IN_WIDTH > MAG_W) ? IN_WIDTH : MAG_W;

    logic w_ce;
    logic r_o_valid;

    assign w_ce = !r_o_valid || m_axis_tready;

    // input buffer
    logic                w_k_valid;
    logic [IN_WIDTH-1:0] w_k_x;

    sau_skid #(
        .WIDTH (IN_WIDTH)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata[IN_WIDTH-1:0]),
        .o_valid (w_k_valid),
        .i_ready (w_ce),
        .o_data  (w_k_x)
    );

    // magnitude and sign, |x| clamped to 32.0
    logic [IN_WIDTH-1:0] w_absx;
    logic [MW-1:0]       w_magx;
    t_ctl                r_a_ctl;
    logic [MAG_W-1:0]    r_a_mag;

    assign w_absx = w_k_x[IN_WIDTH-1] ? (~w_k_x + IN_WIDTH'(1)) : w_k_x;
    assign w_magx = MW'(w_absx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (w_ce) begin
            r_a_ctl.valid <= w_k_valid;
            r_a_ctl.neg   <= w_k_x[IN_WIDTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) r_a_mag <= (w_magx > MW'(A_LIMIT)) ? A_LIMIT : w_magx[MAG_W-1:0];
    end

    // e^-|x|
    t_ctl             w_ex_ctl;
    logic [EXP_W-1:0] w_ex_w;

    sau_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_ctl   (r_a_ctl),
        .i_mag   (r_a_mag),
        .o_ctl   (w_ex_ctl),
        .o_w     (w_ex_w)
    );

    // sigmoid(|x|) = 1 / (1 + e^-|x|)
    t_ctl               w_rc_ctl;
    logic [OUT_WIDTH:0] w_s;

    sau_recip #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_ctl   (w_ex_ctl),
        .i_w     (w_ex_w),
        .o_ctl   (w_rc_ctl),
        .o_s     (w_s)
    );

    // mirror for negative input, saturate the positive side
    logic [OUT_WIDTH-1:0] w_slo;
    logic [OUT_WIDTH-1:0] w_y;
    logic [OUT_WIDTH-1:0] r_o_y;

    assign w_slo = w_s[OUT_WIDTH-1:0];
    assign w_y   = w_rc_ctl.neg ? (~w_slo + OUT_WIDTH'(1)) : (w_s[OUT_WIDTH] ? '1 : w_slo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (w_ce) r_o_valid <= w_rc_ctl.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) r_o_y <= w_y;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_TW'(r_o_y);

    // input buffer only fills while the output is held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input buffer filled without an output stall");

    // sigmoid of a magnitude lies in [0.5, 1.0]
    a_s_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rc_ctl.valid |-> (w_s[OUT_WIDTH] || w_s[OUT_WIDTH-1]))
        else $error("quotient below one half");

    a_s_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rc_ctl.valid && w_s[OUT_WIDTH]) |-> (w_slo == '0))
        else $error("quotient above one");

endmodule

/* tb/sigmoid_activation_unit_core_test.sv */
// Self-checking stream testbench for the sigmoid activation unit core.
`timescale 1ns / 1ps

module sigmoid_activation_unit_core_test;

    localparam int X_W          = 16;
    localparam int Y_W          = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 100;     // a little over the 65-stage pipeline
    localparam int HOLD_CYCLES  = 300;     // long output stall, well past the pipeline depth
    localparam int HOLD_AT      = 500;     // requests sent before the long stall starts
    localparam int CALM_FROM    = 900;     // window of requests with no idling on either side
    localparam int CALM_TO      = 1200;
    localparam int IDLE_PCT     = 31;

    // fixed-point constants of the logistic function
    localparam logic [63:0] LN_E_Q32   = 64'd4294965987;
    localparam logic [63:0] UNIT_Q31   = 64'd2147483648;
    localparam logic [63:0] MAG_CLAMP  = 64'd32768;
    localparam int          TAYLOR_LEN = 13;
    localparam int          SQUARE_CNT = 5;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [X_W-1:0] s_axis_tdata = '0;   // x_value
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [Y_W-1:0] m_axis_tdata;        // y_value

    logic [X_W-1:0] pending_x[$];
    logic [Y_W-1:0] expected_y[$];

    int sent_cnt = 0;
    int checked_cnt = 0;
    int error_cnt = 0;
    int saturated_cnt = 0;
    int backpressure_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    sigmoid_activation_unit_core #(
        .IN_WIDTH (X_W),
        .OUT_WIDTH(Y_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // 1 / (1 + E^-x): Taylor series for E^-|x|/32, five squarings, rounded reciprocal
    function automatic logic [Y_W-1:0] logistic_q16(input logic [X_W-1:0] x);
        logic [63:0] mag;
        logic [63:0] arg;
        logic [63:0] term;
        logic [63:0] even_sum;
        logic [63:0] odd_sum;
        logic [63:0] decay;
        logic [63:0] denom;
        logic [63:0] quot;
        logic [63:0] full_scale;
        logic [63:0] y;
        logic        neg;
        neg = x[X_W-1];
        mag = neg ? ((64'd1 << X_W) - {48'd0, x}) : {48'd0, x};
        if (mag > MAG_CLAMP) mag = MAG_CLAMP;
        arg = (mag * LN_E_Q32 + (64'd1 << 15)) >> 16;
        term = UNIT_Q31;
        even_sum = UNIT_Q31;
        odd_sum = 64'd0;
        for (int n = 1; n <= TAYLOR_LEN; n++) begin
            term = ((term * arg) >> 31) / 64'(n);
            if (n % 2 == 1) odd_sum += term;
            else even_sum += term;
        end
        decay = (even_sum > odd_sum) ? (even_sum - odd_sum) : 64'd0;
        if (decay > UNIT_Q31) decay = UNIT_Q31;
        for (int k = 0; k < SQUARE_CNT; k++) begin
            decay = (decay * decay + (64'd1 << 30)) >> 31;
        end
        denom = UNIT_Q31 + decay;
        quot = ((64'd1 << (31 + Y_W)) + (denom >> 1)) / denom;
        full_scale = 64'd1 << Y_W;
        if (neg) begin
            y = (quot >= full_scale) ? 64'd0 : (full_scale - quot);
        end else begin
            y = (quot > full_scale - 1) ? (full_scale - 1) : quot;
        end
        return y[Y_W-1:0];
    endfunction

    function automatic bit calm_window();
        return sent_cnt >= CALM_FROM && sent_cnt < CALM_TO;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && !s_axis_tready) begin
                backpressure_cycles <= backpressure_cycles + 1;
            end else begin
                if (s_axis_tvalid) begin
                    expected_y.push_back(logistic_q16(s_axis_tdata));
                    sent_cnt <= sent_cnt + 1;
                end
                if (pending_x.size() > 0 &&
                    (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_x.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall control
    always @(posedge i_clk) begin
        logic [Y_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_y.size() == 0) begin
                    $display("%0t: unexpected result y=%h with no request pending",
                             $time, m_axis_tdata);
                    error_cnt <= error_cnt + 1;
                end else begin
                    want = expected_y.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: y_value mismatch expected=%h actual=%h",
                                 $time, want, m_axis_tdata);
                        error_cnt <= error_cnt + 1;
                    end
                    if (want == '0 || want == '1) saturated_cnt <= saturated_cnt + 1;
                    checked_cnt <= checked_cnt + 1;
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        logic [X_W-1:0] corner[$];
        int pick;
        int v;
        // zero, one LSB, full range ends, clamp edge, +-1.0, saturation knee, bit patterns
        corner = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                   16'h7FFE, 16'h0400, 16'hFC00, 16'h0200, 16'hFE00, 16'h2C00,
                   16'hD400, 16'h3000, 16'hD000, 16'h3400, 16'hCC00, 16'h5555,
                   16'hAAAA, 16'h1000, 16'hF000, 16'h0002, 16'hFFFE};
        foreach (corner[i]) pending_x.push_back(corner[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: v = $urandom_range(0, 65535);
                1: v = $urandom_range(0, 24576) - 12288;       // +-12.0, curved region
                2: v = $urandom_range(0, 2048) - 1024;         // +-1.0
                default: begin                                 // around the saturation knee
                    v = $urandom_range(11264, 13312);
                    if ($urandom_range(0, 1)) v = -v;
                end
            endcase
            pending_x.push_back(v[X_W-1:0]);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_x.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_y.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked results, %0d at a saturated end.",
                 sent_cnt, checked_cnt, saturated_cnt);
        $display("Input was held back for %0d cycles, including one long output stall.",
                 backpressure_cycles);
        if (error_cnt == 0 && expected_y.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_y.size());
        $display("Verification failed");
        $finish;
    end

endmodule
